>>> rtl/core/error_history_ring_top_macros.svh
// assertion macros for the error history ring
`ifndef ERROR_HISTORY_RING_TOP_MACROS_SVH
`define ERROR_HISTORY_RING_TOP_MACROS_SVH

// clocked implication, disabled while in reset
`define EHR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// clocked next-cycle implication, disabled while in reset
`define EHR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ehr_pkg.sv
`timescale 1ns / 1ps
package ehr_pkg;

  localparam int CNT_W  = 5;
  localparam int SUB_W  = 8;
  localparam int CODE_W = 16;
  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_REFUSED = 2'd2,
    ST_ABSENT  = 2'd3
  } status_e;

  typedef struct packed {
    logic             sel;
    status_e          status;
    logic [CNT_W-1:0] cnt;
  } res_t;

endpackage

>>> rtl/core/ehr_store.sv
`timescale 1ns / 1ps
module ehr_store import ehr_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WORD_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/core/ehr_ctrl.sv
`timescale 1ns / 1ps
module ehr_ctrl import ehr_pkg::*; #(
  parameter int MAX_DEPTH = 16,
  parameter int ADDR_W    = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CNT_W-1:0]  cfg_data_i,
  input  logic              accept_i,
  input  logic [1:0]        mode_i,
  input  logic [CODE_W-1:0] error_code_i,
  input  logic              has_user_info_i,
  input  logic [CODE_W-1:0] user_info_i,
  input  logic [SUB_W-1:0]  sub_index_i,
  input  logic [SUB_W-1:0]  write_value_i,
  output logic              wr_en_o,
  output logic [ADDR_W-1:0] wr_addr_o,
  output logic [WORD_W-1:0] wr_data_o,
  output logic              rd_en_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  input  logic [WORD_W-1:0] rd_data_i,
  output logic              result_valid_o,
  output logic [WORD_W-1:0] read_data_o,
  output logic [1:0]        status_o
);

  logic [CNT_W-1:0] depth_q, depth_d;
  logic [CNT_W-1:0] newest_q, newest_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             valid_q, valid_d;
  res_t             res_q, res_d;

  logic [CNT_W-1:0] depth_eff;
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] newest_inc;
  logic [CNT_W-1:0] sub_m1;
  logic [CNT_W:0]   map;
  logic             map_ok;

  always_comb begin
    if (int'(depth_q) > MAX_DEPTH) begin
      depth_eff = CNT_W'(MAX_DEPTH);
    end else begin
      depth_eff = depth_q;
    end
    count_eff  = (count_q > depth_eff) ? depth_eff : count_q;
    newest_inc = (newest_q >= depth_eff) ? CNT_W'(1) : newest_q + CNT_W'(1);
    sub_m1     = CNT_W'(sub_index_i - SUB_W'(1));
    if (SUB_W'(newest_q) >= sub_index_i) begin
      map = {1'b0, newest_q} - {1'b0, sub_m1};
    end else begin
      map = {1'b0, depth_eff} - {1'b0, sub_m1} + {1'b0, newest_q};
    end
    map_ok = (map != '0) && (int'(map) - 1 < MAX_DEPTH);
  end

  always_comb begin
    depth_d    = cfg_valid_i ? cfg_data_i : depth_q;
    newest_d   = newest_q;
    count_d    = count_q;
    valid_d    = accept_i;
    res_d      = '{sel: 1'b0, status: ST_OK, cnt: '0};
    wr_en_o    = 1'b0;
    wr_addr_o  = ADDR_W'(newest_inc - CNT_W'(1));
    wr_data_o  = {has_user_info_i ? user_info_i : CODE_W'(0), error_code_i};
    rd_en_o    = 1'b0;
    rd_addr_o  = ADDR_W'(map - (CNT_W + 1)'(1));
    if (accept_i) begin
      case (mode_e'(mode_i))
        MODE_ADD: begin
          if (depth_eff != '0) begin
            wr_en_o  = 1'b1;
            newest_d = newest_inc;
            count_d  = (count_q >= depth_eff) ? depth_eff : count_q + CNT_W'(1);
          end
        end
        MODE_READ: begin
          if (sub_index_i == '0) begin
            res_d.cnt = count_eff;
          end else if (sub_index_i > SUB_W'(depth_eff)) begin
            res_d.status = ST_ABSENT;
          end else if (sub_index_i <= SUB_W'(count_eff) && map_ok) begin
            rd_en_o   = 1'b1;
            res_d.sel = 1'b1;
          end
        end
        MODE_WRITE: begin
          if (sub_index_i != '0) begin
            res_d.status = ST_REFUSED;
          end else if (write_value_i != '0) begin
            res_d.status = ST_RANGE;
          end else begin
            newest_d = '0;
            count_d  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      newest_q <= '0;
      count_q  <= '0;
      valid_q  <= 1'b0;
    end else begin
      depth_q  <= depth_d;
      newest_q <= newest_d;
      count_q  <= count_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = valid_q;
  assign read_data_o    = res_q.sel ? rd_data_i : WORD_W'(res_q.cnt);
  assign status_o       = res_q.status;

endmodule

>>> rtl/core/error_history_ring_top.sv
`timescale 1ns / 1ps
// Error history ring, newest first. A request is taken on every cycle in which start is
// high, since busy stays low: one request per clock. Its result shows on read_data_o and
// status_o in the next cycle, for that one cycle only, with result_valid_o high; the
// receiver cannot stall, so it must take the result in that cycle. The read data come
// from the registered read port of the entry memory. Clearing resets the fill count and
// the newest-entry pointer only. The depth register may be written at any time the
// block is idle; cfg_ready_o is always high.
module error_history_ring_top import ehr_pkg::*; #(
  parameter int MAX_DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CNT_W-1:0]  cfg_data_i,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode_i,
  input  logic [CODE_W-1:0] error_code_i,
  input  logic              has_user_info_i,
  input  logic [CODE_W-1:0] user_info_i,
  input  logic [SUB_W-1:0]  sub_index_i,
  input  logic [SUB_W-1:0]  write_value_i,
  output logic              result_valid_o,
  output logic [WORD_W-1:0] read_data_o,
  output logic [1:0]        status_o
);

  localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  ehr_ctrl #(
    .MAX_DEPTH (MAX_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (start && !busy),
    .mode_i          (mode_i),
    .error_code_i    (error_code_i),
    .has_user_info_i (has_user_info_i),
    .user_info_i     (user_info_i),
    .sub_index_i     (sub_index_i),
    .write_value_i   (write_value_i),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .result_valid_o  (result_valid_o),
    .read_data_o     (read_data_o),
    .status_o        (status_o)
  );

  ehr_store #(
    .DEPTH  (MAX_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

>>> rtl/core/ehr_checker.sv
`timescale 1ns / 1ps
`include "error_history_ring_top_macros.svh"
module ehr_checker import ehr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [1:0]        mode_i,
  input logic [SUB_W-1:0]  sub_index_i,
  input logic              result_valid_o,
  input logic [WORD_W-1:0] read_data_o,
  input logic [1:0]        status_o
);

  `EHR_ASSERT_NEXT(a_result_follows, start && !busy, result_valid_o, "request without result")
  `EHR_ASSERT_NEXT(a_no_spurious, !(start && !busy), !result_valid_o, "result without request")
  `EHR_ASSERT_IMP(a_err_zero_data, result_valid_o && status_o != ST_OK, read_data_o == '0,
    "error result carries data")
  `EHR_ASSERT_NEXT(a_add_result, start && !busy && mode_i == MODE_ADD,
    read_data_o == '0 && status_o == ST_OK, "add result not zero and ok")
  `EHR_ASSERT_NEXT(a_write_refused, start && !busy && mode_i == MODE_WRITE && sub_index_i != '0,
    status_o == ST_REFUSED, "write to nonzero index not refused")

endmodule

bind error_history_ring_top ehr_checker u_ehr_checker (.*);
